// File: hdl/wss_pkg.sv
// types, codes and field widths shared by the sorted stack store and its cells
package wss_pkg;

   localparam int ID_W     = 16;
   localparam int WEIGHT_W = 8;
   localparam int POS_W    = 6;
   localparam int FILL_W   = 7;

   // request operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      CMD_FIND_ID   = 2'd0,
      CMD_FIND_SLOT = 2'd1,
      CMD_DELETE    = 2'd2,
      CMD_INSERT    = 2'd3
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_FULL,
      S_FIND,
      S_DECIDE,
      S_SLOT,
      S_INSERT
   } state_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [ID_W-1:0]       key_id;
      logic [WEIGHT_W-1:0]   key_weight;
   } ctl_type;

   // search token handed from each cell to the one below it
   typedef struct packed {
      logic                  found;
      logic [WEIGHT_W-1:0]   weight;
      logic [POS_W-1:0]      pos;
   } carry_type;

endpackage

// File: hdl/weight_sorted_stack_store.sv
// sorted stack store: sequencer and the chain of slot cells
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    operation, box_id, box_weight
//   rsp      out        rsp_valid/stall    status, position, found_weight, fill_level
//
// a search token ripples down the chain one cell per clock and every search visits
// each cell once; insert, query and remove answer after one search, update after
// two (find, then slot), an insert into a full store without a search; no new
// request is taken until the previous one has been answered
// reset is synchronous and empties the store; cell contents are not cleared
// a stalled response holds the sequencer in its final state until it is taken
module weight_sorted_stack_store
   import wss_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [ID_W-1:0]     req_box_id,
   input  logic [WEIGHT_W-1:0] req_box_weight,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [POS_W-1:0]    rsp_position,
   output logic [WEIGHT_W-1:0] rsp_found_weight,
   output logic [FILL_W-1:0]   rsp_fill_level
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CTR_W = $clog2(CAPACITY);

   state_type           state_ff, state_in;
   logic [CTR_W-1:0]    ctr_ff, ctr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   op_type              op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [WEIGHT_W-1:0] old_ff, old_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [WEIGHT_W-1:0] fweight_ff, fweight_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   ctl_type             ctl;
   logic                rsp_free;
   logic                search_last;
   carry_type           result;

   logic [ID_W-1:0]     cell_id      [CAPACITY];
   logic [WEIGHT_W-1:0] cell_weight  [CAPACITY];
   logic                cell_cond    [CAPACITY];
   carry_type           cell_carry   [CAPACITY];
   logic                below_cond   [CAPACITY];
   logic [ID_W-1:0]     below_id     [CAPACITY];
   logic [WEIGHT_W-1:0] below_weight [CAPACITY];
   logic [ID_W-1:0]     above_id     [CAPACITY];
   logic [WEIGHT_W-1:0] above_weight [CAPACITY];
   carry_type           above_carry  [CAPACITY];
   logic                occupied     [CAPACITY];

   // chain of cells, slot 0 at the bottom
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = count_ff > CNT_W'(i);

      if (i == 0) begin : g_bottom
         assign below_cond[i]   = 1'b1;
         assign below_id[i]     = id_ff;
         assign below_weight[i] = weight_ff;
      end else begin : g_below
         assign below_cond[i]   = cell_cond[i-1];
         assign below_id[i]     = cell_id[i-1];
         assign below_weight[i] = cell_weight[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign above_id[i]     = id_ff;
         assign above_weight[i] = weight_ff;
         assign above_carry[i]  = '0;
      end else begin : g_above
         assign above_id[i]     = cell_id[i+1];
         assign above_weight[i] = cell_weight[i+1];
         assign above_carry[i]  = cell_carry[i+1];
      end

      wss_cell #(
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .occupied     (occupied[i]),
         .below_cond   (below_cond[i]),
         .below_id     (below_id[i]),
         .below_weight (below_weight[i]),
         .above_id     (above_id[i]),
         .above_weight (above_weight[i]),
         .carry_above  (above_carry[i]),
         .cond_out     (cell_cond[i]),
         .slot_id      (cell_id[i]),
         .slot_weight  (cell_weight[i]),
         .carry_out    (cell_carry[i])
      );
   end

   assign result      = cell_carry[0];
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign search_last = ctr_ff == CTR_W'(CAPACITY - 1);

   // sequencer: next state, cell command and response
   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      weight_in    = weight_ff;
      old_in       = old_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      pos_in       = pos_ff;
      fweight_in   = fweight_ff;
      fill_in      = fill_ff;
      ctl.cmd        = CMD_FIND_ID;
      ctl.key_id     = id_ff;
      ctl.key_weight = weight_ff;
      req_stall    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in     = op_type'(req_operation);
               id_in     = req_box_id;
               weight_in = req_box_weight;
               old_in    = '0;
               ctr_in    = '0;
               if (op_type'(req_operation) == OP_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     state_in = S_FULL;
                  end else begin
                     state_in = S_SLOT;
                  end
               end else begin
                  state_in = S_FIND;
               end
            end
         end

         S_FULL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_FULL;
               pos_in       = '0;
               fweight_in   = '0;
               fill_in      = FILL_W'(count_ff);
               state_in     = S_IDLE;
            end
         end

         // token ripples down looking for the topmost matching id
         S_FIND: begin
            ctl.cmd = CMD_FIND_ID;
            ctr_in  = ctr_ff + 1'b1;
            if (search_last) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            ctl.cmd = CMD_FIND_ID;
            if (!result.found) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_NOT_FOUND;
                  pos_in       = '0;
                  fweight_in   = '0;
                  fill_in      = FILL_W'(count_ff);
                  state_in     = S_IDLE;
               end
            end else if (op_ff == OP_QUERY) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_DONE;
                  pos_in       = result.pos;
                  fweight_in   = result.weight;
                  fill_in      = FILL_W'(count_ff);
                  state_in     = S_IDLE;
               end
            end else if (op_ff == OP_REMOVE) begin
               if (rsp_free) begin
                  ctl.cmd      = CMD_DELETE;
                  count_in     = count_ff - 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_DONE;
                  pos_in       = result.pos;
                  fweight_in   = result.weight;
                  fill_in      = FILL_W'(count_in);
                  state_in     = S_IDLE;
               end
            end else begin
               // update: drop the old entry, then look for its new slot
               ctl.cmd  = CMD_DELETE;
               count_in = count_ff - 1'b1;
               old_in   = result.weight;
               ctr_in   = '0;
               state_in = S_SLOT;
            end
         end

         // token ripples down looking for the insertion boundary
         S_SLOT: begin
            ctl.cmd = CMD_FIND_SLOT;
            ctr_in  = ctr_ff + 1'b1;
            if (search_last) begin
               state_in = S_INSERT;
            end
         end

         S_INSERT: begin
            ctl.cmd = CMD_FIND_SLOT;
            if (rsp_free) begin
               ctl.cmd      = CMD_INSERT;
               count_in     = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DONE;
               pos_in       = result.pos;
               fweight_in   = old_ff;
               fill_in      = FILL_W'(count_in);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      id_ff      <= id_in;
      weight_ff  <= weight_in;
      old_ff     <= old_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      fweight_ff <= fweight_in;
      fill_ff    <= fill_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_position     = pos_ff;
   assign rsp_found_weight = fweight_ff;
   assign rsp_fill_level   = fill_ff;

endmodule

// File: hdl/wss_cell.sv
// one slot of the sorted stack: holds an entry, passes the search token down
module wss_cell
   import wss_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  logic                occupied,
   input  logic                below_cond,
   input  logic [ID_W-1:0]     below_id,
   input  logic [WEIGHT_W-1:0] below_weight,
   input  logic [ID_W-1:0]     above_id,
   input  logic [WEIGHT_W-1:0] above_weight,
   input  carry_type           carry_above,
   output logic                cond_out,
   output logic [ID_W-1:0]     slot_id,
   output logic [WEIGHT_W-1:0] slot_weight,
   output carry_type           carry_out
);

   logic [ID_W-1:0]     id_ff, id_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   carry_type           carry_ff, carry_in;
   logic                cond_self;
   logic                hit;

   // entry stays below a new one of this weight
   assign cond_self = occupied && (weight_ff >= ctl.key_weight);

   // local match: topmost id hit, or the insertion boundary
   always_comb begin
      case (ctl.cmd)
         CMD_FIND_ID:   hit = occupied && (id_ff == ctl.key_id);
         CMD_FIND_SLOT: hit = below_cond && !cond_self;
         default:       hit = 1'b0;
      endcase
   end

   // token: a hit from above wins, else this cell may claim it
   always_comb begin
      carry_in = carry_ff;
      if (ctl.cmd == CMD_FIND_ID || ctl.cmd == CMD_FIND_SLOT) begin
         if (carry_above.found) begin
            carry_in = carry_above;
         end else if (hit) begin
            carry_in.found  = 1'b1;
            carry_in.weight = weight_ff;
            carry_in.pos    = POS_W'(INDEX);
         end else begin
            carry_in = '0;
         end
      end
   end

   // shift on delete (from above) and on insert (from below)
   always_comb begin
      id_in     = id_ff;
      weight_in = weight_ff;
      case (ctl.cmd)
         CMD_DELETE: begin
            if (!carry_above.found) begin
               id_in     = above_id;
               weight_in = above_weight;
            end
         end
         CMD_INSERT: begin
            if (!cond_self) begin
               if (below_cond) begin
                  id_in     = ctl.key_id;
                  weight_in = ctl.key_weight;
               end else begin
                  id_in     = below_id;
                  weight_in = below_weight;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      weight_ff <= weight_in;
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   assign cond_out    = cond_self;
   assign slot_id     = id_ff;
   assign slot_weight = weight_ff;
   assign carry_out   = carry_ff;

endmodule
